### src/bnc_pkg.sv
// Package for the biquad notch cascade: sizes, register indexes, stage map,
// controller-to-datapath command and status types.
// No dependencies.
`default_nettype none

package bnc_pkg;

  localparam int FIXED_STAGES    = 2;
  localparam int ADAPTIVE_STAGES = 4;
  localparam int SAMPLE_BITS     = 24;

  localparam int STAGE_COUNT = 6;
  localparam int STAGE_W     = $clog2(STAGE_COUNT);
  localparam int CNT_W       = $clog2(STAGE_COUNT + 1);
  localparam int COEF_BITS   = 20;
  localparam int COEF_FRAC   = 18;
  localparam int CFG_W       = 61;
  localparam int CFG_IDX_W   = 3;
  localparam int ACC_W       = 32;
  localparam int MUL_A_W     = ACC_W + 1;
  localparam int MUL_W       = MUL_A_W + COEF_BITS;
  localparam int STR_W       = 16;
  localparam int BLEND_FRAC  = 15;
  localparam logic [STR_W-1:0] FULL_STRENGTH = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS   = 3'd7;

  typedef enum logic [1:0] {
    MUL_B0X = 2'd0,
    MUL_B1D = 2'd1,
    MUL_A2Y = 2'd2,
    MUL_SD  = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    POST_NONE = 3'd0,
    POST_Y    = 3'd1,
    POST_N1   = 3'd2,
    POST_N2   = 3'd3,
    POST_OUT  = 3'd4
  } post_op_t;

  typedef struct packed {
    logic                load;
    logic                out_load;
    mul_op_t             mul_op;
    post_op_t            post_op;
    logic [STAGE_W-1:0]  stage;
  } cmd_t;

  typedef struct packed {
    logic [STAGE_COUNT-1:0] stage_on;
    logic                   suppress;
  } status_t;

  function automatic logic stage_built(input int i);
    if (i < 2) begin
      return i < FIXED_STAGES;
    end
    return (i - 2) < ADAPTIVE_STAGES;
  endfunction

endpackage

`default_nettype wire

### src/bnc_in_if.sv
// Input channel of the notch cascade: valid/ready plus one audio item.
// Depends on bnc_pkg.
`default_nettype none

interface bnc_in_if
  import bnc_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_in;
  logic                          buffer_end_in;

  modport source (output valid, output audio_in, output buffer_end_in, input ready);
  modport sink (input valid, input audio_in, input buffer_end_in, output ready);
endinterface

`default_nettype wire

### src/bnc_out_if.sv
// Output channel of the notch cascade: valid/ready plus one result item.
// Depends on bnc_pkg.
`default_nettype none

interface bnc_out_if
  import bnc_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;
  logic                          buffer_end_out;

  modport source (output valid, output audio_out, output buffer_end_out, input ready);
  modport sink (input valid, input audio_out, input buffer_end_out, output ready);
endinterface

`default_nettype wire

### src/bnc_datapath.sv
// Datapath of the notch cascade: config registers, delay state, one shared
// multiplier with product register, rounding/saturation and output register.
// Depends on bnc_pkg.
`default_nettype none

module bnc_datapath
  import bnc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire cmd_t                          cmd,
  output status_t                            status,
  input  wire logic signed [SAMPLE_BITS-1:0] audio_in,
  input  wire logic                          buffer_end_in,
  output logic signed [SAMPLE_BITS-1:0]      audio_out,
  output logic                               buffer_end_out
);

  localparam logic signed [ACC_W:0] OUT_MAX =
    (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] OUT_MIN = -OUT_MAX - 1;
  localparam logic signed [55:0] HALF18 = 56'sd1 <<< (COEF_FRAC - 1);
  localparam logic signed [55:0] HALF15 = 56'sd1 <<< (BLEND_FRAC - 1);

  logic [CFG_W-1:0]        setup [STAGE_COUNT];
  logic signed [ACC_W-1:0] z1 [STAGE_COUNT];
  logic signed [ACC_W-1:0] z2 [STAGE_COUNT];
  logic [STR_W-1:0]        strength;
  logic                    suppress;

  logic signed [ACC_W-1:0] x_acc;
  logic signed [ACC_W-1:0] y_reg;
  logic signed [MUL_W-1:0] prod;
  logic signed [MUL_W-1:0] p0;
  logic                    mark;

  logic signed [COEF_BITS-1:0] b0, b1, a2;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [COEF_BITS-1:0] mul_b;
  logic signed [55:0]          prod_x, q_a, q_b, q_c;
  logic signed [ACC_W-1:0]     y_new, n1_new, n2_new, x_new;
  logic [STR_W-1:0]            str_in;

  function automatic logic signed [ACC_W-1:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -56'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[ACC_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < STAGE_COUNT; i++) begin
      status.stage_on[i] = setup[i][0] && stage_built(i);
    end
    status.suppress = suppress;
  end

  assign b0 = setup[cmd.stage][20:1];
  assign b1 = setup[cmd.stage][40:21];
  assign a2 = setup[cmd.stage][60:41];

  always_comb begin
    case (cmd.mul_op)
      MUL_B0X: begin
        mul_a = MUL_A_W'(x_acc);
        mul_b = b0;
      end
      MUL_B1D: begin
        mul_a = MUL_A_W'(x_acc) - MUL_A_W'(y_reg);
        mul_b = b1;
      end
      MUL_A2Y: begin
        mul_a = MUL_A_W'(y_reg);
        mul_b = a2;
      end
      default: begin
        mul_a = MUL_A_W'(y_reg) - MUL_A_W'(x_acc);
        mul_b = $signed(COEF_BITS'(strength));
      end
    endcase
  end

  always_comb begin
    prod_x = 56'(prod);
    q_a    = (prod_x + HALF18) >>> COEF_FRAC;
    q_b    = (56'(p0) - prod_x + HALF18) >>> COEF_FRAC;
    q_c    = (prod_x + HALF15) >>> BLEND_FRAC;
    y_new  = sat32(q_a + 56'(z1[cmd.stage]));
    n1_new = sat32(q_a + 56'(z2[cmd.stage]));
    n2_new = sat32(q_b);
    x_new  = sat32(q_c + 56'(x_acc));
  end

  assign str_in = (cfg_data[STR_W-1:0] > FULL_STRENGTH) ? FULL_STRENGTH : cfg_data[STR_W-1:0];

  // config and delay state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        setup[i] <= '0;
        z1[i]    <= '0;
        z2[i]    <= '0;
      end
      strength <= FULL_STRENGTH;
      suppress <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index <= REG_STAGE_LAST) begin
        setup[cfg_index[STAGE_W-1:0]] <= cfg_data;
        z1[cfg_index[STAGE_W-1:0]]    <= '0;
        z2[cfg_index[STAGE_W-1:0]]    <= '0;
      end else if (cfg_index == REG_STRENGTH) begin
        strength <= str_in;
      end else if (cfg_index == REG_SUPPRESS) begin
        suppress <= cfg_data[0];
      end
    end else begin
      if (cmd.post_op == POST_N1) begin
        z1[cmd.stage] <= n1_new;
      end
      if (cmd.post_op == POST_N2) begin
        z2[cmd.stage] <= n2_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      x_acc <= ACC_W'(audio_in);
      mark  <= buffer_end_in;
    end else if (cmd.post_op == POST_OUT) begin
      x_acc <= x_new;
    end
    if (cmd.post_op == POST_Y) begin
      y_reg <= y_new;
      p0    <= prod;
    end
    if (cmd.out_load) begin
      if ((ACC_W+1)'(x_acc) > OUT_MAX) begin
        audio_out <= OUT_MAX[SAMPLE_BITS-1:0];
      end else if ((ACC_W+1)'(x_acc) < OUT_MIN) begin
        audio_out <= OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
        audio_out <= x_acc[SAMPLE_BITS-1:0];
      end
      buffer_end_out <= mark;
    end
  end

endmodule

`default_nettype wire

### src/bnc_ctrl.sv
// Controller of the notch cascade: walks the stages, sequences the shared
// multiplier, owns input ready and output valid. Depends on bnc_pkg.
`default_nettype none

module bnc_ctrl
  import bnc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_PH0  = 9'b000000100,
    S_PH1  = 9'b000001000,
    S_PH2  = 9'b000010000,
    S_PH3  = 9'b000100000,
    S_PH4  = 9'b001000000,
    S_PH5  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             cur_on;

  assign cur_on = (idx < CNT_W'(STAGE_COUNT)) && status.stage_on[idx[STAGE_W-1:0]];

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.mul_op   = MUL_B0X;
    cmd.post_op  = POST_NONE;
    cmd.stage    = idx[STAGE_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = status.suppress ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (idx == CNT_W'(STAGE_COUNT)) begin
          state_next = S_FIN;
        end else if (cur_on) begin
          state_next = S_PH0;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_PH0: begin
        cmd.mul_op = MUL_B0X;
        state_next = S_PH1;
      end
      S_PH1: begin
        cmd.post_op = POST_Y;
        state_next  = S_PH2;
      end
      S_PH2: begin
        cmd.mul_op = MUL_B1D;
        state_next = S_PH3;
      end
      S_PH3: begin
        cmd.post_op = POST_N1;
        cmd.mul_op  = MUL_A2Y;
        state_next  = S_PH4;
      end
      S_PH4: begin
        cmd.post_op = POST_N2;
        cmd.mul_op  = MUL_SD;
        state_next  = S_PH5;
      end
      S_PH5: begin
        cmd.post_op = POST_OUT;
        idx_next    = idx + CNT_W'(1);
        state_next  = S_SCAN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an unread item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accept");

  a_stage_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == S_PH0) |-> (idx < CNT_W'(STAGE_COUNT) && cur_on))
    else $error("running a stage that is off");

  a_valid_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without handshake");
`endif

endmodule

`default_nettype wire

### src/biquad_notch_cascade_blend_core.sv
// Top level of the biquad notch cascade with strength blend.
// Depends on bnc_pkg, bnc_in_if, bnc_out_if, bnc_ctrl, bnc_datapath.
//
// Usage:
//   din  carries one signed sample and a buffer end mark per item; dout
//   returns exactly one saturated sample per item, in order.
//   cfg_we/cfg_index/cfg_data write stage setups (0..5), strength (6) and
//   suppression (7); write only while no item is in flight. A stage write
//   clears that stage's delay state; suppression on enables filtering.
// Timing:
//   One item at a time, through a single shared multiplier. The item is
//   scanned across the stages; each enabled stage runs PH0..PH5 and
//   costs four products on the one multiplier. FIN then loads the
//   result; with suppression off it goes straight to FIN. The next
//   item can be taken in the cycle after the result is loaded.
// Reset (rst, synchronous): stages off, delays zero, full strength,
//   suppression on, channels empty.
// Stall: a result waits in the output register while the next item is
//   accepted and computed; the core holds before loading a new result
//   until the old one is taken.
`default_nettype none

module biquad_notch_cascade_blend_core
  import bnc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bnc_in_if.sink                    din,
  bnc_out_if.source                 dout
);

  cmd_t    cmd;
  status_t status;

  bnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bnc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .audio_in       (din.audio_in),
    .buffer_end_in  (din.buffer_end_in),
    .audio_out      (dout.audio_out),
    .buffer_end_out (dout.buffer_end_out)
  );

endmodule

`default_nettype wire
